[rtl/eqfp_pkg.sv]
// ----------------------------------------------------------------------------
// eqfp_pkg
// Shared types, constants and codes of the ECG QRS feature preprocessor.
// ----------------------------------------------------------------------------
package eqfp_pkg;

    // default sizes of the delay lines and the gain scale
    localparam int COMB_DEPTH_DEF    = 256;
    localparam int DEQUE_DEPTH_DEF   = 512;
    localparam int AGC_DEPTH_DEF     = 512;
    localparam int PRODUCT_DEPTH_DEF = 8;
    localparam int SUM_DEPTH_DEF     = 1024;
    localparam int GAIN_LOG2_DEF     = 15;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 18;
    localparam int IDX_W      = 16;
    localparam int FEAT_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LPF_HALF_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGC_DELAY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGC_FLOOR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_ORDER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_WINDOW      = 3'd5;

    // configuration reset values
    localparam logic [7:0]  RST_LPF_HALF_WINDOW = 8'd6;
    localparam logic [13:0] RST_MAX_WINDOW      = 14'd720;
    localparam logic [8:0]  RST_AGC_DELAY       = 9'd18;
    localparam logic [14:0] RST_AGC_FLOOR       = 15'd8;
    localparam logic [2:0]  RST_PRODUCT_ORDER   = 3'd3;
    localparam logic [9:0]  RST_SUM_WINDOW      = 10'd36;

    // controller states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_COMB2,
        S_COMB_FIN,
        S_WALK_START,
        S_WALK_CMP,
        S_INSERT,
        S_POP_RD,
        S_POP_CHK,
        S_GAIN_RD,
        S_GAIN_CAP,
        S_DIV_INIT,
        S_DIV_STEP,
        S_Q_SET,
        S_MUL_LOAD,
        S_MUL_STEP,
        S_MUL_SAVE,
        S_FINISH
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_COMB2,
        OP_COMB_FIN,
        OP_WALK_START,
        OP_WALK_CMP,
        OP_INSERT,
        OP_POP_RD,
        OP_POP_CHK,
        OP_GAIN_RD,
        OP_GAIN_CAP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_Q_SET,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_SAVE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] fidx;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       j_zero;
        logic       j_one;
        logic       walk_pop;
        logic       div_needed;
        logic       out_free;
        logic [2:0] kk;
    } dp_status_t;

endpackage

[rtl/eqfp_ram.sv]
// ----------------------------------------------------------------------------
// eqfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eqfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/eqfp_ctrl.sv]
// ----------------------------------------------------------------------------
// eqfp_ctrl
// Sequencer that steps the datapath through one sample at a time.
// ----------------------------------------------------------------------------
module eqfp_ctrl #(
    parameter int GAIN_LOG2 = eqfp_pkg::GAIN_LOG2_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output eqfp_pkg::dp_cmd_t    cmd,
    input  eqfp_pkg::dp_status_t status
);

    localparam int DIV_W  = eqfp_pkg::MAG_W + GAIN_LOG2;
    localparam int STEP_W = $clog2(DIV_W);

    eqfp_pkg::ctrl_state_t state_reg, state_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]            fidx_reg, fidx_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eqfp_pkg::S_CLEAR;
            cnt_reg   <= '0;
            fidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fidx_reg  <= fidx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fidx_next  = fidx_reg;
        case (state_reg)
            eqfp_pkg::S_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = eqfp_pkg::S_IDLE;
                end
            end
            eqfp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = eqfp_pkg::S_COMB2;
                end
            end
            eqfp_pkg::S_COMB2:      state_next = eqfp_pkg::S_COMB_FIN;
            eqfp_pkg::S_COMB_FIN:   state_next = eqfp_pkg::S_WALK_START;
            eqfp_pkg::S_WALK_START:
            begin
                state_next = status.j_zero ? eqfp_pkg::S_INSERT : eqfp_pkg::S_WALK_CMP;
            end
            eqfp_pkg::S_WALK_CMP:
            begin
                if (!(status.walk_pop && !status.j_one))
                begin
                    state_next = eqfp_pkg::S_INSERT;
                end
            end
            eqfp_pkg::S_INSERT:     state_next = eqfp_pkg::S_POP_RD;
            eqfp_pkg::S_POP_RD:     state_next = eqfp_pkg::S_POP_CHK;
            eqfp_pkg::S_POP_CHK:    state_next = eqfp_pkg::S_GAIN_RD;
            eqfp_pkg::S_GAIN_RD:    state_next = eqfp_pkg::S_GAIN_CAP;
            eqfp_pkg::S_GAIN_CAP:   state_next = eqfp_pkg::S_DIV_INIT;
            eqfp_pkg::S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = status.div_needed ? eqfp_pkg::S_DIV_STEP : eqfp_pkg::S_Q_SET;
            end
            eqfp_pkg::S_DIV_STEP:
            begin
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = eqfp_pkg::S_Q_SET;
                end
            end
            eqfp_pkg::S_Q_SET:
            begin
                fidx_next  = 2'd1;
                state_next = (status.kk == 3'd1) ? eqfp_pkg::S_FINISH : eqfp_pkg::S_MUL_LOAD;
            end
            eqfp_pkg::S_MUL_LOAD:
            begin
                cnt_next   = '0;
                state_next = eqfp_pkg::S_MUL_STEP;
            end
            eqfp_pkg::S_MUL_STEP:
            begin
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(GAIN_LOG2 - 1))
                begin
                    state_next = eqfp_pkg::S_MUL_SAVE;
                end
            end
            eqfp_pkg::S_MUL_SAVE:
            begin
                fidx_next = fidx_reg + 2'd1;
                if ({1'b0, fidx_reg} == status.kk - 3'd1)
                begin
                    state_next = eqfp_pkg::S_FINISH;
                end
                else
                begin
                    state_next = eqfp_pkg::S_MUL_LOAD;
                end
            end
            eqfp_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = eqfp_pkg::S_IDLE;
                end
            end
            default:                state_next = eqfp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = eqfp_pkg::OP_NOP;
        cmd.fidx = fidx_reg;
        in_stall = (state_reg != eqfp_pkg::S_IDLE);
        case (state_reg)
            eqfp_pkg::S_CLEAR:      cmd.op = eqfp_pkg::OP_CLEAR;
            eqfp_pkg::S_IDLE:
            begin
                cmd.op = in_valid ? eqfp_pkg::OP_LOAD : eqfp_pkg::OP_NOP;
            end
            eqfp_pkg::S_COMB2:      cmd.op = eqfp_pkg::OP_COMB2;
            eqfp_pkg::S_COMB_FIN:   cmd.op = eqfp_pkg::OP_COMB_FIN;
            eqfp_pkg::S_WALK_START: cmd.op = eqfp_pkg::OP_WALK_START;
            eqfp_pkg::S_WALK_CMP:   cmd.op = eqfp_pkg::OP_WALK_CMP;
            eqfp_pkg::S_INSERT:     cmd.op = eqfp_pkg::OP_INSERT;
            eqfp_pkg::S_POP_RD:     cmd.op = eqfp_pkg::OP_POP_RD;
            eqfp_pkg::S_POP_CHK:    cmd.op = eqfp_pkg::OP_POP_CHK;
            eqfp_pkg::S_GAIN_RD:    cmd.op = eqfp_pkg::OP_GAIN_RD;
            eqfp_pkg::S_GAIN_CAP:   cmd.op = eqfp_pkg::OP_GAIN_CAP;
            eqfp_pkg::S_DIV_INIT:   cmd.op = eqfp_pkg::OP_DIV_INIT;
            eqfp_pkg::S_DIV_STEP:   cmd.op = eqfp_pkg::OP_DIV_STEP;
            eqfp_pkg::S_Q_SET:      cmd.op = eqfp_pkg::OP_Q_SET;
            eqfp_pkg::S_MUL_LOAD:   cmd.op = eqfp_pkg::OP_MUL_LOAD;
            eqfp_pkg::S_MUL_STEP:   cmd.op = eqfp_pkg::OP_MUL_STEP;
            eqfp_pkg::S_MUL_SAVE:   cmd.op = eqfp_pkg::OP_MUL_SAVE;
            eqfp_pkg::S_FINISH:
            begin
                cmd.op = status.out_free ? eqfp_pkg::OP_FINISH : eqfp_pkg::OP_NOP;
            end
            default:                cmd.op = eqfp_pkg::OP_NOP;
        endcase
    end

endmodule

[rtl/eqfp_datapath.sv]
// ----------------------------------------------------------------------------
// eqfp_datapath
// Delay lines, max deque, serial divider, serial multiplier and moving sum.
// ----------------------------------------------------------------------------
module eqfp_datapath #(
    parameter int COMB_DEPTH    = eqfp_pkg::COMB_DEPTH_DEF,
    parameter int DEQUE_DEPTH   = eqfp_pkg::DEQUE_DEPTH_DEF,
    parameter int AGC_DEPTH     = eqfp_pkg::AGC_DEPTH_DEF,
    parameter int PRODUCT_DEPTH = eqfp_pkg::PRODUCT_DEPTH_DEF,
    parameter int SUM_DEPTH     = eqfp_pkg::SUM_DEPTH_DEF,
    parameter int GAIN_LOG2     = eqfp_pkg::GAIN_LOG2_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [eqfp_pkg::SAMPLE_W-1:0] ecg_sample,
    input  logic                                 cfg_we,
    input  logic [eqfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eqfp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [eqfp_pkg::FEAT_W-1:0]          feature_value,
    input  eqfp_pkg::dp_cmd_t                    cmd,
    output eqfp_pkg::dp_status_t                 status
);

    localparam int G      = GAIN_LOG2;
    localparam int MW     = eqfp_pkg::MAG_W;
    localparam int IW     = eqfp_pkg::IDX_W;
    localparam int FW     = eqfp_pkg::FEAT_W;
    localparam int CAW    = $clog2(COMB_DEPTH);
    localparam int DAW    = $clog2(DEQUE_DEPTH);
    localparam int AAW    = $clog2(AGC_DEPTH);
    localparam int SAW    = $clog2(SUM_DEPTH);
    localparam int CLR_A  = (COMB_DEPTH > AGC_DEPTH) ? COMB_DEPTH : AGC_DEPTH;
    localparam int CLR_N  = (CLR_A > SUM_DEPTH) ? CLR_A : SUM_DEPTH;
    localparam int CLRW   = $clog2(CLR_N);
    localparam int DIV_W  = MW + G;
    localparam int PROD_W = 4 * G;
    localparam int DQ_W   = MW + IW;
    localparam logic [G-1:0] LIM = '1;

    // configuration registers
    logic [7:0]  lpf_reg;
    logic [13:0] maxw_reg;
    logic [8:0]  dly_reg;
    logic [14:0] floor_reg;
    logic [2:0]  order_reg;
    logic [9:0]  sumw_reg;

    // control state
    logic [IW-1:0]   idx_reg, idx_next;
    logic [DAW-1:0]  head_reg, head_next;
    logic [DAW:0]    count_reg, count_next;
    logic [FW-1:0]   rsum_reg, rsum_next;
    logic [G-1:0]    pline_reg [PRODUCT_DEPTH];
    logic [G-1:0]    pline_next [PRODUCT_DEPTH];
    logic            out_valid_reg, out_valid_next;
    logic [CLRW-1:0] clr_reg, clr_next;

    // payload
    logic signed [eqfp_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [eqfp_pkg::SAMPLE_W-1:0] c1_reg, c1_next;
    logic [MW-1:0]     delayed_reg, delayed_next;
    logic [G-1:0]      old_reg, old_next;
    logic [MW-1:0]     mag_reg, mag_next;
    logic [DAW:0]      j_reg, j_next;
    logic [MW-1:0]     gain_reg, gain_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [MW:0]       rem_reg, rem_next;
    logic [G-1:0]      q_reg, q_next;
    logic [PROD_W-1:0] pacc_reg, pacc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [G-1:0]      mult_reg, mult_next;
    logic [FW-1:0]     feat_reg, feat_next;

    // memory ports
    logic           comb_we, agc_we, sum_we, dq_we;
    logic [CAW-1:0] comb_waddr, comb_raddr;
    logic [AAW-1:0] agc_waddr, agc_raddr;
    logic [SAW-1:0] sum_waddr, sum_raddr;
    logic [DAW-1:0] dq_waddr, dq_raddr;
    logic [eqfp_pkg::SAMPLE_W-1:0] comb_wdata, comb_rdata;
    logic [MW-1:0]  agc_wdata, agc_rdata;
    logic [G-1:0]   sum_wdata, sum_rdata;
    logic [DQ_W-1:0] dq_wdata, dq_rdata;

    // helper terms
    logic [IW-1:0]     back1, back2, back_agc, back_sum, tag_due;
    logic [13:0]       win;
    logic [2:0]        kk;
    logic signed [MW:0] y;
    logic [MW-1:0]     mag_calc, dq_val;
    logic              walk_pop;
    logic              j_full;
    logic [DAW-1:0]    head_a;
    logic [DAW:0]      j_a;
    logic [MW:0]       div_t;
    logic              div_ge;
    logic [DIV_W-1:0]  dly_ext;
    logic [G-1:0]      factor;
    logic [PROD_W-1:0] p_shift;
    logic [G-1:0]      p_val;

    eqfp_ram #(.WIDTH(eqfp_pkg::SAMPLE_W), .DEPTH(COMB_DEPTH)) u_comb_ram (
        .clk   (clk),
        .we    (comb_we),
        .waddr (comb_waddr),
        .wdata (comb_wdata),
        .raddr (comb_raddr),
        .rdata (comb_rdata)
    );

    eqfp_ram #(.WIDTH(MW), .DEPTH(AGC_DEPTH)) u_agc_ram (
        .clk   (clk),
        .we    (agc_we),
        .waddr (agc_waddr),
        .wdata (agc_wdata),
        .raddr (agc_raddr),
        .rdata (agc_rdata)
    );

    eqfp_ram #(.WIDTH(G), .DEPTH(SUM_DEPTH)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // deque entry: magnitude over sample tag
    eqfp_ram #(.WIDTH(DQ_W), .DEPTH(DEQUE_DEPTH)) u_dq_ram (
        .clk   (clk),
        .we    (dq_we),
        .waddr (dq_waddr),
        .wdata (dq_wdata),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    // line offsets and fixed helpers
    always_comb
    begin
        back1    = idx_reg - IW'(lpf_reg);
        back2    = idx_reg - {7'd0, lpf_reg, 1'b0};
        back_agc = idx_reg - IW'(dly_reg);
        back_sum = idx_reg - IW'(sumw_reg);
        win      = (maxw_reg == 14'd0) ? 14'd1 : maxw_reg;
        tag_due  = idx_reg - IW'(win);
        if (order_reg == 3'd0)
        begin
            kk = 3'd1;
        end
        else if (order_reg > 3'd4)
        begin
            kk = 3'd4;
        end
        else
        begin
            kk = order_reg;
        end
        y        = (MW+1)'(sample_reg) - ((MW+1)'(c1_reg) <<< 1)
                   + (MW+1)'($signed(comb_rdata));
        mag_calc = y[MW] ? MW'(-y) : MW'(y);
        dq_val   = dq_rdata[DQ_W-1:IW];
        walk_pop = (mag_reg >= dq_val);
        j_full   = j_reg[DAW];
        head_a   = j_full ? head_reg + DAW'(1) : head_reg;
        j_a      = j_full ? (DAW+1)'(DEQUE_DEPTH - 1) : j_reg;
        div_t    = {rem_reg[MW-1:0], dvd_reg[DIV_W-1]};
        div_ge   = (div_t >= {1'b0, gain_reg});
        dly_ext  = DIV_W'(delayed_reg);
        case (cmd.fidx)
            2'd1:    factor = pline_reg[0];
            2'd2:    factor = pline_reg[1];
            default: factor = pline_reg[2];
        endcase
        case (kk)
            3'd1:    p_shift = pacc_reg;
            3'd2:    p_shift = pacc_reg >> G;
            3'd3:    p_shift = pacc_reg >> (2 * G);
            default: p_shift = pacc_reg >> (3 * G);
        endcase
        p_val    = p_shift[G-1:0];
    end

    // status to the controller
    always_comb
    begin
        status.clr_last   = (clr_reg == CLRW'(CLR_N - 1));
        status.j_zero     = (j_reg == '0);
        status.j_one      = (j_reg == (DAW+1)'(1));
        status.walk_pop   = walk_pop;
        status.div_needed = (gain_reg >= MW'(floor_reg)) && (gain_reg != '0);
        status.out_free   = !out_valid_reg || !out_stall;
        status.kk         = kk;
    end

    // operation decode
    always_comb
    begin
        idx_next       = idx_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rsum_next      = rsum_reg;
        pline_next     = pline_reg;
        out_valid_next = out_valid_reg && out_stall;
        clr_next       = clr_reg;
        sample_next    = sample_reg;
        c1_next        = c1_reg;
        delayed_next   = delayed_reg;
        old_next       = old_reg;
        mag_next       = mag_reg;
        j_next         = j_reg;
        gain_next      = gain_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        pacc_next      = pacc_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        mult_next      = mult_reg;
        feat_next      = feat_reg;

        comb_we    = 1'b0;
        comb_waddr = idx_reg[CAW-1:0];
        comb_wdata = sample_reg;
        comb_raddr = back1[CAW-1:0];
        agc_we     = 1'b0;
        agc_waddr  = idx_reg[AAW-1:0];
        agc_wdata  = mag_reg;
        agc_raddr  = back_agc[AAW-1:0];
        sum_we     = 1'b0;
        sum_waddr  = idx_reg[SAW-1:0];
        sum_wdata  = p_val;
        sum_raddr  = back_sum[SAW-1:0];
        dq_we      = 1'b0;
        dq_waddr   = head_a + j_a[DAW-1:0];
        dq_wdata   = {mag_reg, idx_reg};
        dq_raddr   = head_reg + j_reg[DAW-1:0] - DAW'(1);

        case (cmd.op)
            // zero sweep of the delay lines after reset
            eqfp_pkg::OP_CLEAR:
            begin
                comb_we    = 1'b1;
                comb_waddr = clr_reg[CAW-1:0];
                comb_wdata = '0;
                agc_we     = 1'b1;
                agc_waddr  = clr_reg[AAW-1:0];
                agc_wdata  = '0;
                sum_we     = 1'b1;
                sum_waddr  = clr_reg[SAW-1:0];
                sum_wdata  = '0;
                clr_next   = clr_reg + CLRW'(1);
            end
            eqfp_pkg::OP_LOAD:
            begin
                sample_next = ecg_sample;
            end
            eqfp_pkg::OP_COMB2:
            begin
                c1_next      = $signed(comb_rdata);
                delayed_next = agc_rdata;
                old_next     = sum_rdata;
                comb_raddr   = back2[CAW-1:0];
            end
            // comb difference, magnitude and line write
            eqfp_pkg::OP_COMB_FIN:
            begin
                mag_next = mag_calc;
                comb_we  = 1'b1;
                j_next   = count_reg;
            end
            eqfp_pkg::OP_WALK_START:
            begin
                agc_we = 1'b1;
            end
            // drop tail entries not above the new magnitude
            eqfp_pkg::OP_WALK_CMP:
            begin
                if (walk_pop)
                begin
                    j_next   = j_reg - (DAW+1)'(1);
                    dq_raddr = head_reg + j_reg[DAW-1:0] - DAW'(2);
                end
            end
            eqfp_pkg::OP_INSERT:
            begin
                dq_we      = 1'b1;
                head_next  = head_a;
                count_next = j_a + (DAW+1)'(1);
            end
            eqfp_pkg::OP_POP_RD:
            begin
                dq_raddr = head_reg;
            end
            // retire the head when the window is exceeded
            eqfp_pkg::OP_POP_CHK:
            begin
                if ((IW'(count_reg) > IW'(win)) || (dq_rdata[IW-1:0] == tag_due))
                begin
                    head_next  = head_reg + DAW'(1);
                    count_next = count_reg - (DAW+1)'(1);
                end
            end
            eqfp_pkg::OP_GAIN_RD:
            begin
                dq_raddr = head_reg;
            end
            eqfp_pkg::OP_GAIN_CAP:
            begin
                gain_next = dq_val;
            end
            eqfp_pkg::OP_DIV_INIT:
            begin
                dvd_next = {delayed_reg, {G{1'b0}}};
                rem_next = '0;
            end
            // restoring division, one quotient bit per cycle
            eqfp_pkg::OP_DIV_STEP:
            begin
                rem_next = div_ge ? div_t - {1'b0, gain_reg} : div_t;
                dvd_next = {dvd_reg[DIV_W-2:0], div_ge};
            end
            // gain scaled value with saturation, unscaled below the floor
            eqfp_pkg::OP_Q_SET:
            begin
                if (gain_reg >= MW'(floor_reg))
                begin
                    if (gain_reg == '0)
                    begin
                        q_next = LIM;
                    end
                    else
                    begin
                        q_next = (dvd_reg > DIV_W'(LIM)) ? LIM : dvd_reg[G-1:0];
                    end
                end
                else
                begin
                    q_next = (dly_ext > DIV_W'(LIM)) ? LIM : dly_ext[G-1:0];
                end
                pacc_next = PROD_W'(q_next);
            end
            eqfp_pkg::OP_MUL_LOAD:
            begin
                mcand_next = pacc_reg;
                prod_next  = '0;
                mult_next  = factor;
            end
            // shift-add multiply, one multiplier bit per cycle
            eqfp_pkg::OP_MUL_STEP:
            begin
                if (mult_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
            end
            eqfp_pkg::OP_MUL_SAVE:
            begin
                pacc_next = prod_reg;
            end
            // moving sum, gain scaled value history and result register
            eqfp_pkg::OP_FINISH:
            begin
                sum_we    = 1'b1;
                rsum_next = rsum_reg + FW'(p_val) - FW'(old_reg);
                pline_next[0] = q_reg;
                for (int i = 1; i < PRODUCT_DEPTH; i++)
                begin
                    pline_next[i] = pline_reg[i-1];
                end
                idx_next       = idx_reg + IW'(1);
                out_valid_next = 1'b1;
                feat_next      = rsum_next;
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpf_reg   <= eqfp_pkg::RST_LPF_HALF_WINDOW;
            maxw_reg  <= eqfp_pkg::RST_MAX_WINDOW;
            dly_reg   <= eqfp_pkg::RST_AGC_DELAY;
            floor_reg <= eqfp_pkg::RST_AGC_FLOOR;
            order_reg <= eqfp_pkg::RST_PRODUCT_ORDER;
            sumw_reg  <= eqfp_pkg::RST_SUM_WINDOW;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eqfp_pkg::CFG_LPF_HALF_WINDOW: lpf_reg   <= cfg_data[7:0];
                eqfp_pkg::CFG_MAX_WINDOW:      maxw_reg  <= cfg_data[13:0];
                eqfp_pkg::CFG_AGC_DELAY:       dly_reg   <= cfg_data[8:0];
                eqfp_pkg::CFG_AGC_FLOOR:       floor_reg <= cfg_data[14:0];
                eqfp_pkg::CFG_PRODUCT_ORDER:   order_reg <= cfg_data[2:0];
                eqfp_pkg::CFG_SUM_WINDOW:      sumw_reg  <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
            for (int i = 0; i < PRODUCT_DEPTH; i++)
            begin
                pline_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsum_reg      <= rsum_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            pline_reg     <= pline_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        c1_reg      <= c1_next;
        delayed_reg <= delayed_next;
        old_reg     <= old_next;
        mag_reg     <= mag_next;
        j_reg       <= j_next;
        gain_reg    <= gain_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        pacc_reg    <= pacc_next;
        mcand_reg   <= mcand_next;
        prod_reg    <= prod_next;
        mult_reg    <= mult_next;
        feat_reg    <= feat_next;
    end

    assign out_valid     = out_valid_reg;
    assign feature_value = feat_reg;

endmodule

[rtl/ecg_qrs_feature_preprocessor.sv]
// ----------------------------------------------------------------------------
// ecg_qrs_feature_preprocessor
// Comb difference, sliding-max gain control, product and moving sum of ECG.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid, in_stall, ecg_sample            sample in
//  out       out_valid, out_stall, feature_value       feature out
//  cfg       cfg_we, cfg_index, cfg_data               register write
//
//  one sample in flight; each runs the comb, a walk dropping deque entries
//  not above the new magnitude (up to the deque depth, one deque read per
//  cycle), the gain read, the divider, K-1 multiplies; K the product order
//  the divider yields one quotient bit per cycle, the multiplier one bit
//  after reset a zero sweep clears every delay line entry before the first
//  sample is taken
//  a finished feature waits in the output register; the next sample is taken
//  while it is stalled
// ----------------------------------------------------------------------------
module ecg_qrs_feature_preprocessor #(
    parameter int COMB_DEPTH    = eqfp_pkg::COMB_DEPTH_DEF,
    parameter int DEQUE_DEPTH   = eqfp_pkg::DEQUE_DEPTH_DEF,
    parameter int AGC_DEPTH     = eqfp_pkg::AGC_DEPTH_DEF,
    parameter int PRODUCT_DEPTH = eqfp_pkg::PRODUCT_DEPTH_DEF,
    parameter int SUM_DEPTH     = eqfp_pkg::SUM_DEPTH_DEF,
    parameter int GAIN_LOG2     = eqfp_pkg::GAIN_LOG2_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [eqfp_pkg::SAMPLE_W-1:0] ecg_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [eqfp_pkg::FEAT_W-1:0]          feature_value,
    input  logic                                 cfg_we,
    input  logic [eqfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eqfp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    eqfp_pkg::dp_cmd_t    cmd;
    eqfp_pkg::dp_status_t status;

    // sequencer
    eqfp_ctrl #(.GAIN_LOG2(GAIN_LOG2)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath
    eqfp_datapath #(
        .COMB_DEPTH    (COMB_DEPTH),
        .DEQUE_DEPTH   (DEQUE_DEPTH),
        .AGC_DEPTH     (AGC_DEPTH),
        .PRODUCT_DEPTH (PRODUCT_DEPTH),
        .SUM_DEPTH     (SUM_DEPTH),
        .GAIN_LOG2     (GAIN_LOG2)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ecg_sample    (ecg_sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .feature_value (feature_value),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

[rtl/eqfp_checker.sv]
// ----------------------------------------------------------------------------
// eqfp_checker
// Port-level checks of the preprocessor, bound to the top level.
// ----------------------------------------------------------------------------
module eqfp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [eqfp_pkg::FEAT_W-1:0]     feature_value
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(feature_value))
        else $error("result changed while stalled");

    // one sample in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while one is in flight");

    // a transfer in never produces a result on the next edge
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after a sample transfer");

    // a new result coincides with the block going ready
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result raised while input still stalled");

endmodule

bind ecg_qrs_feature_preprocessor eqfp_checker u_eqfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .feature_value (feature_value)
);
